// ===== rtl/frame_difference_pixel_mask_unit_assert.svh =====
// Assertion macros shared by the frame difference pixel mask checkers.
`ifndef FRAME_DIFFERENCE_PIXEL_MASK_UNIT_ASSERT_SVH
`define FRAME_DIFFERENCE_PIXEL_MASK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDPM_ASSERT_IMP(label, clock, rst_n, pre, post) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("frame difference mask: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define FDPM_ASSERT_NXT(label, clock, rst_n, pre, post) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("frame difference mask: property violated");

`endif

// ===== rtl/fdpm_pkg.sv =====
// Shared types, constants and helpers of the frame difference pixel mask.
package fdpm_pkg;

	localparam int COUNTER_BITS = 12;
	// Wide enough for a counter or configured size plus a margin, without overflow.
	localparam int CMP_W = ((COUNTER_BITS > 12) ? COUNTER_BITS : 12) + 2;
	localparam int CH_W = 8;
	localparam int NUM_CH = 3;
	localparam int PIX_W = CH_W * NUM_CH;
	localparam int WIN = 5;
	localparam int PHASE_W = 2;
	localparam int LAST_PHASE = 2;
	localparam int MIN_WIDTH = 5;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [COUNTER_BITS-1:0] cnt_t;
	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_LINE_PIXELS = 3'd0;
	localparam reg_idx_t REG_FRAME_LINES = 3'd1;
	localparam reg_idx_t REG_BORDER_MARGIN = 3'd2;
	localparam reg_idx_t REG_BLUE_LIMIT = 3'd3;
	localparam reg_idx_t REG_GREEN_LIMIT = 3'd4;
	localparam reg_idx_t REG_RED_LIMIT = 3'd5;

	typedef struct packed {
		logic [11:0] line_pixels;
		logic [11:0] frame_lines;
		logic [7:0] border_margin;
		logic [7:0] blue_limit;
		logic [7:0] green_limit;
		logic [7:0] red_limit;
	} cfg_t;

	// One result's worth of window, position and flags, handed to the mask logic.
	typedef struct packed {
		logic valid;
		pix_t [WIN-1:0] ref_win;
		pix_t [WIN-1:0] cur_win;
		pix_t pixel;
		cnt_t col;
		cnt_t row;
		logic line_end;
		logic frame_end;
		logic burst_last;
	} sel_t;

	typedef struct packed {
		pix_t pixel;
		logic line_end;
		logic frame_end;
		logic burst_last;
	} res_t;

	function automatic logic [11:0] eff_width(input cfg_t c);
		return (c.line_pixels < 12'(MIN_WIDTH)) ? 12'(MIN_WIDTH) : c.line_pixels;
	endfunction

	function automatic logic [11:0] eff_height(input cfg_t c);
		return (c.frame_lines == 12'd0) ? 12'd1 : c.frame_lines;
	endfunction

endpackage

// ===== rtl/fdpm_window.sv =====
// Pixel history, line and row counters, and the window stage that sequences results.
module fdpm_window (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fdpm_pkg::pix_t ref_pix,
	input  fdpm_pkg::pix_t cur_pix,
	input  fdpm_pkg::cfg_t cfg,
	input  logic           advance,
	output fdpm_pkg::sel_t sel
);
	import fdpm_pkg::*;

	typedef struct packed {
		pix_t [WIN-1:0] ref_win;
		pix_t [WIN-1:0] cur_win;
		cnt_t col;
		cnt_t row;
		logic last;
		logic frame_last;
		logic emit;
	} item_t;

	localparam int FULL = WIN + 2;

	pix_t ref_hist_q [4];
	pix_t cur_hist_q [4];
	cnt_t col_q;
	cnt_t row_q;
	logic valid_s1;
	logic [PHASE_W-1:0] phase_s1;
	item_t item_s1;

	logic accept;
	logic last_in;
	logic frame_last_in;
	logic final_phase;
	logic done;
	item_t item_d;
	pix_t ref_full [FULL];
	pix_t cur_full [FULL];

	assign last_in = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(eff_width(cfg));
	assign frame_last_in = (CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(eff_height(cfg));
	assign accept = in_valid && in_ready;
	assign final_phase = !item_s1.last || (phase_s1 == PHASE_W'(LAST_PHASE));
	assign done = valid_s1 && (!item_s1.emit || (advance && final_phase));
	assign in_ready = !valid_s1 || done;

	always_comb begin
		item_d.ref_win[0] = ref_hist_q[3];
		item_d.ref_win[1] = ref_hist_q[2];
		item_d.ref_win[2] = ref_hist_q[1];
		item_d.ref_win[3] = ref_hist_q[0];
		item_d.ref_win[4] = ref_pix;
		item_d.cur_win[0] = cur_hist_q[3];
		item_d.cur_win[1] = cur_hist_q[2];
		item_d.cur_win[2] = cur_hist_q[1];
		item_d.cur_win[3] = cur_hist_q[0];
		item_d.cur_win[4] = cur_pix;
		item_d.col = col_q;
		item_d.row = row_q;
		item_d.last = last_in;
		item_d.frame_last = frame_last_in;
		item_d.emit = last_in || (col_q >= cnt_t'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				ref_hist_q[k] <= '0;
				cur_hist_q[k] <= '0;
			end
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_in) begin
				for (int k = 0; k < 4; k++) begin
					ref_hist_q[k] <= '0;
					cur_hist_q[k] <= '0;
				end
				col_q <= '0;
				row_q <= frame_last_in ? '0 : row_q + cnt_t'(1);
			end else begin
				for (int k = 3; k > 0; k--) begin
					ref_hist_q[k] <= ref_hist_q[k-1];
					cur_hist_q[k] <= cur_hist_q[k-1];
				end
				ref_hist_q[0] <= ref_pix;
				cur_hist_q[0] <= cur_pix;
				col_q <= col_q + cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && item_s1.emit && advance) begin
				phase_s1 <= final_phase ? '0 : phase_s1 + PHASE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

	// Lines end in zeros: the two slots past the newest pixel are empty.
	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			ref_full[k] = item_s1.ref_win[k];
			cur_full[k] = item_s1.cur_win[k];
		end
		for (int k = WIN; k < FULL; k++) begin
			ref_full[k] = '0;
			cur_full[k] = '0;
		end
		for (int j = 0; j < WIN; j++) begin
			sel.ref_win[j] = ref_full[3'(phase_s1) + 3'(j)];
			sel.cur_win[j] = cur_full[3'(phase_s1) + 3'(j)];
		end
		sel.valid = valid_s1 && item_s1.emit;
		sel.pixel = cur_full[3'(phase_s1) + 3'(2)];
		sel.col = item_s1.col - cnt_t'(2) + cnt_t'(phase_s1);
		sel.row = item_s1.row;
		sel.line_end = item_s1.last && final_phase;
		sel.frame_end = item_s1.last && final_phase && item_s1.frame_last;
		sel.burst_last = final_phase;
	end

endmodule

// ===== rtl/fdpm_mask.sv =====
// Box averages, difference test and border test for one result pixel.
module fdpm_mask (
	input  fdpm_pkg::sel_t sel,
	input  fdpm_pkg::cfg_t cfg,
	output fdpm_pkg::res_t res
);
	import fdpm_pkg::*;

	localparam int SUM_W = CH_W + 3;
	localparam int PROD_W = SUM_W + 16;
	localparam int DIV5_RECIP = 52429;
	localparam int DIV5_SHIFT = 18;

	// Exact quotient by five for every sum of five channel values.
	function automatic logic [CH_W-1:0] div5(input logic [SUM_W-1:0] x);
		logic [PROD_W-1:0] p;
		p = PROD_W'(x) * PROD_W'(DIV5_RECIP);
		return p[DIV5_SHIFT +: CH_W];
	endfunction

	logic [SUM_W-1:0] sum_ref [NUM_CH];
	logic [SUM_W-1:0] sum_cur [NUM_CH];
	logic [CH_W-1:0] avg_ref [NUM_CH];
	logic [CH_W-1:0] avg_cur [NUM_CH];
	logic [CH_W-1:0] diff [NUM_CH];
	logic [CH_W-1:0] lim [NUM_CH];
	logic keep;
	logic border;
	logic [CMP_W-1:0] row_w, col_w, m_w, w_w, h_w;

	assign lim[0] = cfg.blue_limit;
	assign lim[1] = cfg.green_limit;
	assign lim[2] = cfg.red_limit;

	always_comb begin
		keep = 1'b0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sum_ref[ch] = '0;
			sum_cur[ch] = '0;
			for (int j = 0; j < WIN; j++) begin
				sum_ref[ch] = sum_ref[ch] + SUM_W'(sel.ref_win[j][ch*CH_W +: CH_W]);
				sum_cur[ch] = sum_cur[ch] + SUM_W'(sel.cur_win[j][ch*CH_W +: CH_W]);
			end
			avg_ref[ch] = div5(sum_ref[ch]);
			avg_cur[ch] = div5(sum_cur[ch]);
			diff[ch] = (avg_ref[ch] > avg_cur[ch]) ? avg_ref[ch] - avg_cur[ch]
			                                       : avg_cur[ch] - avg_ref[ch];
			keep = keep || (diff[ch] > lim[ch]);
		end
	end

	// Upper border tests are written as position plus margin, so nothing goes negative.
	always_comb begin
		row_w = CMP_W'(sel.row);
		col_w = CMP_W'(sel.col);
		m_w = CMP_W'(cfg.border_margin);
		w_w = CMP_W'(eff_width(cfg));
		h_w = CMP_W'(eff_height(cfg));
		border = (row_w < m_w) || ((row_w + m_w) > h_w)
		      || (col_w < m_w) || ((col_w + m_w) > w_w);
		res.pixel = (keep && !border) ? sel.pixel : '0;
		res.line_end = sel.line_end;
		res.frame_end = sel.frame_end;
		res.burst_last = sel.burst_last;
	end

endmodule

// ===== rtl/frame_difference_pixel_mask_unit.sv =====
// Frame difference pixel mask: top level with configuration registers and result register.
//
// The block takes one pixel pair per request (reference and current frame, BGR, raster
// order) and can accept a new request in every clock cycle, bar the stalls below. Each
// result pixel is the current pixel, kept when the truncated five-pixel horizontal box
// average of any channel differs between the two frames by more than that channel's
// limit, and zeroed otherwise or inside the border margin. Results trail the input by
// two columns: the first two requests of a line give no result, and the request that ends
// a line gives three results, for its own column and the two before it. That line-end
// request holds the single window stage, s_tready low, until the one result register has
// taken all three; s_tready is also low while a result waits on m_tready. Otherwise the
// rate is one pixel per cycle. A result goes from the window stage through the mask logic
// into the output register. m_tlast marks the last pixel of a line, m_tuser[0] the last
// pixel of a frame and m_tuser[1] the last result that a request causes. Configuration
// registers must only be written while the block is idle, with all results delivered.
module frame_difference_pixel_mask_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Pixel pair requests.
	input  logic        s_tvalid,
	output logic        s_tready,
	// From bit 0: ref_blue, ref_green, ref_red, cur_blue, cur_green, cur_red.
	input  logic [47:0] s_tdata,
	// Result requests.
	output logic        m_tvalid,
	input  logic        m_tready,
	// From bit 0: out_blue, out_green, out_red.
	output logic [23:0] m_tdata,
	// line_end.
	output logic        m_tlast,
	// From bit 0: frame_end, burst_last.
	output logic [1:0]  m_tuser,
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import fdpm_pkg::*;

	cfg_t cfg_q;
	sel_t sel;
	res_t res_d;
	res_t res_q;
	logic m_valid_q;
	logic advance;

	// The result register can take a new result when empty or when being emptied.
	assign advance = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_pixels <= 12'd640;
			cfg_q.frame_lines <= 12'd480;
			cfg_q.border_margin <= 8'd20;
			cfg_q.blue_limit <= 8'd10;
			cfg_q.green_limit <= 8'd10;
			cfg_q.red_limit <= 8'd5;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_PIXELS: begin
					cfg_q.line_pixels <= cfg_data;
				end
				REG_FRAME_LINES: begin
					cfg_q.frame_lines <= cfg_data;
				end
				REG_BORDER_MARGIN: begin
					cfg_q.border_margin <= cfg_data[7:0];
				end
				REG_BLUE_LIMIT: begin
					cfg_q.blue_limit <= cfg_data[7:0];
				end
				REG_GREEN_LIMIT: begin
					cfg_q.green_limit <= cfg_data[7:0];
				end
				REG_RED_LIMIT: begin
					cfg_q.red_limit <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	// History, counters and the window stage, handing out one result per cycle on advance.
	fdpm_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.ref_pix  (s_tdata[23:0]),
		.cur_pix  (s_tdata[47:24]),
		.cfg      (cfg_q),
		.advance  (advance),
		.sel      (sel)
	);

	// Averages, difference and border decisions for the selected result.
	fdpm_mask u_mask (
		.sel (sel),
		.cfg (cfg_q),
		.res (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= sel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && sel.valid) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = res_q.pixel;
	assign m_tlast = res_q.line_end;
	assign m_tuser = {res_q.burst_last, res_q.frame_end};

endmodule

// ===== rtl/fdpm_checker.sv =====
// Port-level checker for the frame difference pixel mask, bound to the top level.
`include "frame_difference_pixel_mask_unit_assert.svh"

module fdpm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic [1:0]  m_tuser
);

	// A stalled result stays offered and unchanged.
	`FDPM_ASSERT_NXT(a_result_held, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

	// The end of a line is always the final result of its request.
	`FDPM_ASSERT_IMP(a_line_end_closes_burst, clk, arst_n, m_tvalid && m_tlast, m_tuser[1])

	// The end of a frame only ever falls on the end of a line.
	`FDPM_ASSERT_IMP(a_frame_end_on_line_end, clk, arst_n, m_tvalid && m_tuser[0], m_tlast)

endmodule

bind frame_difference_pixel_mask_unit fdpm_checker u_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench of the frame difference pixel mask unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fdpm_pkg::*;

	// Tracks the masked pixels that the block should deliver. It mirrors the
	// configuration and the per-line pixel history, and for every accepted pixel
	// pair queues the results that this pair completes, oldest first.
	class masked_pixel_tracker;
		cfg_t cfg;
		pix_t ref_hist [4];
		pix_t cur_hist [4];
		pix_t ref_win [7];
		pix_t cur_win [7];
		int col_pos;
		int row_pos;
		int line_w;
		int frame_h;
		res_t awaited_pixels [$];
		int errors;

		function new();
			int k;
			cfg.line_pixels = 12'd640;
			cfg.frame_lines = 12'd480;
			cfg.border_margin = 8'd20;
			cfg.blue_limit = 8'd10;
			cfg.green_limit = 8'd10;
			cfg.red_limit = 8'd5;
			for (k = 0; k < 4; k++) begin
				ref_hist[k] = '0;
				cur_hist[k] = '0;
			end
			col_pos = 0;
			row_pos = 0;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [11:0] val);
			case (idx)
				REG_LINE_PIXELS: cfg.line_pixels = val;
				REG_FRAME_LINES: cfg.frame_lines = val;
				REG_BORDER_MARGIN: cfg.border_margin = val[7:0];
				REG_BLUE_LIMIT: cfg.blue_limit = val[7:0];
				REG_GREEN_LIMIT: cfg.green_limit = val[7:0];
				REG_RED_LIMIT: cfg.red_limit = val[7:0];
				default: ;
			endcase
		endfunction

		// Truncated mean of one channel over the five pixels around the centre.
		function int box_mean(bit of_ref, int centre, int ch);
			int k;
			int sum;
			pix_t px;
			sum = 0;
			for (k = centre - 2; k <= centre + 2; k++) begin
				px = of_ref ? ref_win[k] : cur_win[k];
				sum += int'(px[ch*8 +: 8]);
			end
			return sum / 5;
		endfunction

		function void queue_pixel(int centre, int px_col, bit le, bit fe, bit bl);
			int m;
			int ch;
			int diff;
			int lim;
			bit border;
			bit keep;
			res_t r;
			m = int'(cfg.border_margin);
			border = row_pos < m || row_pos > frame_h - m || px_col < m || px_col > line_w - m;
			keep = 1'b0;
			if (!border) begin
				for (ch = 0; ch < 3; ch++) begin
					diff = box_mean(1'b1, centre, ch) - box_mean(1'b0, centre, ch);
					if (diff < 0) begin
						diff = -diff;
					end
					lim = (ch == 0) ? int'(cfg.blue_limit) :
						(ch == 1) ? int'(cfg.green_limit) : int'(cfg.red_limit);
					if (diff > lim) begin
						keep = 1'b1;
					end
				end
			end
			r.pixel = keep ? cur_win[centre] : '0;
			r.line_end = le;
			r.frame_end = fe;
			r.burst_last = bl;
			awaited_pixels = {awaited_pixels, r};
		endfunction

		function void note_pixel_pair(pix_t ref_px, pix_t cur_px);
			int k;
			int wrap;
			bit line_done;
			bit frame_done;
			wrap = (1 << COUNTER_BITS) - 1;
			line_w = (cfg.line_pixels < 12'd5) ? 5 : int'(cfg.line_pixels);
			frame_h = (cfg.frame_lines == 12'd0) ? 1 : int'(cfg.frame_lines);
			line_done = col_pos + 1 >= line_w;
			frame_done = row_pos + 1 >= frame_h;
			// Window slots 0..3 hold the history oldest first, slot 4 the new pair,
			// and the slots past the line's last pixel read as zero.
			for (k = 0; k < 4; k++) begin
				ref_win[k] = ref_hist[3 - k];
				cur_win[k] = cur_hist[3 - k];
			end
			ref_win[4] = ref_px;
			cur_win[4] = cur_px;
			ref_win[5] = '0;
			ref_win[6] = '0;
			cur_win[5] = '0;
			cur_win[6] = '0;
			if (line_done) begin
				for (k = 2; k <= 4; k++) begin
					queue_pixel(k, col_pos - (4 - k), k == 4, k == 4 && frame_done, k == 4);
				end
				for (k = 0; k < 4; k++) begin
					ref_hist[k] = '0;
					cur_hist[k] = '0;
				end
				col_pos = 0;
				row_pos = frame_done ? 0 : ((row_pos + 1) & wrap);
			end else begin
				if (col_pos >= 2) begin
					queue_pixel(2, col_pos - 2, 1'b0, 1'b0, 1'b1);
				end
				for (k = 3; k > 0; k--) begin
					ref_hist[k] = ref_hist[k - 1];
					cur_hist[k] = cur_hist[k - 1];
				end
				ref_hist[0] = ref_px;
				cur_hist[0] = cur_px;
				col_pos = (col_pos + 1) & wrap;
			end
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_masked_pixel(res_t got);
			res_t want;
			if (awaited_pixels.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual pixel %06h flags %b%b%b",
					$time, got.pixel, got.line_end, got.frame_end, got.burst_last);
				return;
			end
			want = awaited_pixels.pop_front();
			compare_field("pixel", want.pixel, got.pixel);
			compare_field("line_end", want.line_end, got.line_end);
			compare_field("frame_end", want.frame_end, got.frame_end);
			compare_field("burst_last", want.burst_last, got.burst_last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [47:0] s_tdata = '0;
	logic m_tready = 1'b0;
	logic cfg_we = 1'b0;
	reg_idx_t cfg_index = REG_LINE_PIXELS;
	logic [11:0] cfg_data = '0;
	logic s_tready;
	logic m_tvalid;
	logic [23:0] m_tdata;
	logic m_tlast;
	logic [1:0] m_tuser;

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int dir_idx = 0;

	masked_pixel_tracker tracker = new();

	// Directed pixel pairs: full-scale differences both ways, equal extremes, and a
	// one-channel step that moves the blue average by exactly one.
	pix_t dir_ref [6] = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000005, 24'h80FF01};
	pix_t dir_cur [6] = '{24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h7FFE00};

	always #4 clk = ~clk;

	frame_difference_pixel_mask_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Result side. Outputs are read straight after the rising edge, before any
	// register of the block has taken its new value, so they are the values that
	// the edge saw. The ready for the next edge is then chosen at random.
	initial begin
		res_t got;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.pixel = m_tdata;
				got.line_end = m_tlast;
				got.frame_end = m_tuser[0];
				got.burst_last = m_tuser[1];
				tracker.check_masked_pixel(got);
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// One register write; the enable is lowered for a cycle so that two writes
	// in a row never touch it twice in one time step.
	task automatic write_reg(reg_idx_t idx, logic [11:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		tracker.write_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stops sending and waits until every queued result has come out, then lets
	// a pair that causes no result of its own clear the window stage as well.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.awaited_pixels.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_setup(int w, int h, int m, int b, int g, int r);
		wait_idle();
		write_reg(REG_LINE_PIXELS, 12'(w));
		write_reg(REG_FRAME_LINES, 12'(h));
		write_reg(REG_BORDER_MARGIN, 12'(m));
		write_reg(REG_BLUE_LIMIT, 12'(b));
		write_reg(REG_GREEN_LIMIT, 12'(g));
		write_reg(REG_RED_LIMIT, 12'(r));
	endtask

	// Offers one pixel pair, after a random number of idle cycles, and holds it
	// until the block takes it. The request is accepted at the edge where valid
	// and ready are both high; ready is read as it stood at that edge.
	task automatic send_pair(pix_t ref_px, pix_t cur_px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {cur_px, ref_px};
		do @(posedge clk); while (!s_tready);
		tracker.note_pixel_pair(ref_px, cur_px);
	endtask

	task automatic send_directed(int n);
		int i;
		for (i = 0; i < n; i++) begin
			send_pair(dir_ref[dir_idx % 6], dir_cur[dir_idx % 6]);
			dir_idx++;
		end
	endtask

	// Random pair: the current pixel is often the reference or close to it, so
	// that both kept and zeroed pixels turn up away from the border.
	task automatic send_random_pair();
		pix_t ref_px;
		pix_t cur_px;
		int ch;
		int v;
		ref_px = $urandom();
		if ($urandom_range(3) == 0) begin
			for (ch = 0; ch < 3; ch++) begin
				ref_px[ch*8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
			end
		end
		case ($urandom_range(3))
			0: begin
				cur_px = $urandom();
			end
			1: begin
				cur_px = ref_px;
			end
			default: begin
				for (ch = 0; ch < 3; ch++) begin
					v = int'(ref_px[ch*8 +: 8]) + int'($urandom_range(24)) - 12;
					v = (v < 0) ? 0 : (v > 255) ? 255 : v;
					cur_px[ch*8 +: 8] = 8'(v);
				end
			end
		endcase
		send_pair(ref_px, cur_px);
	endtask

	function automatic int random_limit();
		int pick;
		pick = $urandom_range(9);
		return (pick == 0) ? 0 : (pick == 1) ? 255 : int'($urandom_range(30));
	endfunction

	initial begin
		int phase;
		int n;
		int w;
		int m;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset: a few pairs at the reset settings, all inside the border.
		send_directed(3);
		// Narrowest line, no margin and zero limits. The three columns left over
		// from the reset settings carry on into the first short line.
		program_setup(5, 3, 0, 0, 0, 0);
		send_directed(11);
		// A width below the minimum acts as five and a zero height as one, so
		// every line ends a frame; limits at full scale keep nothing.
		program_setup(3, 0, 1, 255, 255, 255);
		send_directed(5);
		// Widest line and largest margin, then a narrower width while the line is
		// under way: the next pair closes the line with three results.
		program_setup(4095, 4095, 255, 20, 7, 128);
		send_directed(6);
		wait_idle();
		write_reg(REG_LINE_PIXELS, 12'd6);
		send_directed(1);

		// Random frames under each handshake pressure: none, sender gaps, receiver
		// stalls and both. Mostly short lines and thin margins, so that most rows
		// and columns clear the border.
		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 62 : (phase == 3) ? 24 : 0;
			recv_stall_pct = (phase == 2) ? 62 : (phase == 3) ? 24 : 0;
			w = ($urandom_range(9) == 0) ? int'($urandom_range(4)) : int'($urandom_range(5, 12));
			m = ($urandom_range(4) == 0) ? int'($urandom_range(3, 4)) : int'($urandom_range(2));
			program_setup(w, $urandom_range(6), m, random_limit(), random_limit(),
				random_limit());
			for (n = 0; n < 22; n++) begin
				// Halfway through the sender-gap phase, hold off until the block
				// has delivered everything, partway through a line.
				if (phase == 1 && n == 11) begin
					wait_idle();
				end
				send_random_pair();
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.awaited_pixels.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#1000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
